FILE: sv/rgbemb_pkg.sv
// Shared types, constants and the emboss kernel table for the RGB emboss filter.
package rgbemb_pkg;

  localparam int MaxWidth    = 2048;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int HeightLimit = 4096;
  localparam int RowW        = $clog2(HeightLimit);
  localparam int KselW       = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 13;
  localparam int ChanW       = 8;
  localparam int PixW        = 3 * ChanW;
  localparam int TapCount    = 9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0] pix_t;
  typedef chan_t [TapCount-1:0] win_t;
  typedef logic signed [1:0] coef_t;
  typedef coef_t [TapCount-1:0] kern_t;

  localparam coef_t CoefPos = 2'sd1;
  localparam coef_t CoefNeg = -2'sd1;

  // One write to the combined line store: upper row in the high half, middle in the low half.
  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
    pix_t            upper;
    pix_t            middle;
  } store_wr_t;

  // Kernel entries in row-major order; only the four corners are ever nonzero.
  function automatic kern_t emb_kernel(input logic [KselW-1:0] sel);
    kern_t k;
    k = '0;
    unique case (sel)
      3'd0: begin
        k[0] = CoefNeg; k[8] = CoefPos;
      end
      3'd1: begin
        k[0] = CoefPos; k[8] = CoefNeg;
      end
      3'd2: begin
        k[2] = CoefNeg; k[6] = CoefPos;
      end
      3'd3: begin
        k[2] = CoefPos; k[6] = CoefNeg;
      end
      3'd4: begin
        k[0] = CoefNeg; k[2] = CoefNeg; k[6] = CoefPos; k[8] = CoefPos;
      end
      3'd5: begin
        k[0] = CoefNeg; k[2] = CoefPos; k[6] = CoefPos; k[8] = CoefNeg;
      end
      3'd6: begin
        k[0] = CoefPos; k[2] = CoefPos; k[6] = CoefNeg; k[8] = CoefNeg;
      end
      3'd7: begin
        k[0] = CoefPos; k[2] = CoefNeg; k[6] = CoefNeg; k[8] = CoefPos;
      end
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/rgbemb_line_store.sv
// Combined two-row line store: one memory, one write and one registered read per cycle.
module rgbemb_line_store (
  input  logic                          clk,
  input  rgbemb_pkg::store_wr_t         wr,
  input  logic                          rd_en,
  input  logic [rgbemb_pkg::ColW-1:0]   rd_addr,
  output rgbemb_pkg::pix_t              rd_upper,
  output rgbemb_pkg::pix_t              rd_middle
);

  logic [2*rgbemb_pkg::PixW-1:0] mem [rgbemb_pkg::MaxWidth];
  logic [2*rgbemb_pkg::PixW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.upper, wr.middle};
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_upper  = rd_data_r[2*rgbemb_pkg::PixW-1:rgbemb_pkg::PixW];
  assign rd_middle = rd_data_r[rgbemb_pkg::PixW-1:0];

endmodule

FILE: sv/rgbemb_lane.sv
// One color lane: flipped 3x3 emboss convolution of a window and clamp to 0..255.
module rgbemb_lane (
  input  logic [rgbemb_pkg::KselW-1:0] kernel_sel,
  input  rgbemb_pkg::win_t             win,
  output rgbemb_pkg::chan_t            result
);

  rgbemb_pkg::kern_t  kern;
  logic signed [8:0]  term [rgbemb_pkg::TapCount];
  logic signed [10:0] part0, part1, part2, acc;

  always_comb begin
    kern = rgbemb_pkg::emb_kernel(kernel_sel);
    // Window cell i meets kernel entry 8-i (convolution flip)
    for (int i = 0; i < rgbemb_pkg::TapCount; i++) begin
      if (kern[rgbemb_pkg::TapCount-1-i] == rgbemb_pkg::CoefPos) begin
        term[i] = $signed({1'b0, win[i]});
      end else if (kern[rgbemb_pkg::TapCount-1-i] == rgbemb_pkg::CoefNeg) begin
        term[i] = -$signed({1'b0, win[i]});
      end else begin
        term[i] = '0;
      end
    end
    part0 = 11'(term[0]) + 11'(term[1]) + 11'(term[2]);
    part1 = 11'(term[3]) + 11'(term[4]) + 11'(term[5]);
    part2 = 11'(term[6]) + 11'(term[7]) + 11'(term[8]);
    acc   = part0 + part1 + part2;
    if (acc < 0) begin
      result = '0;
    end else if (acc > 11'sd255) begin
      result = '1;
    end else begin
      result = acc[7:0];
    end
  end

endmodule

FILE: sv/rgb_emboss_filter_3x3.sv
// Top level of the 3x3 RGB emboss filter: counters, window, lanes and output register.
//
// Takes one padded RGB pixel per clock in raster order while in_stall is low and returns
// one filtered pixel per clock while out_stall is low once a full 3x3 window exists (from
// the third row and third column on), with frame_end set on the last result of the frame.
// An accepted beat and its line store read are registered in stage 1; when stage 1 advances,
// the three channel lanes run and the output register is loaded. The output register parts
// the two sides, so a new beat is taken while a result waits; outside the clearing sweep,
// in_stall rises only when that result is held back and stage 1 holds a beat. After reset
// the line store is cleared one column per cycle, with in_stall high. Write the configuration
// only while no beat is in flight; the kernel, width or height then apply from the next beat on.
module rgb_emboss_filter_3x3 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_red_in,
  input  logic [7:0]                        in_green_in,
  input  logic [7:0]                        in_blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_red_out,
  output logic [7:0]                        out_green_out,
  output logic [7:0]                        out_blue_out,
  output logic                              out_frame_end,
  input  logic                              cfg_wr_en,
  input  logic [rgbemb_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rgbemb_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int ColW = rgbemb_pkg::ColW;
  localparam int RowW = rgbemb_pkg::RowW;

  // Configuration
  logic [rgbemb_pkg::KselW-1:0] kernel_sel_r;
  logic [11:0]                  frame_width_r;
  logic [12:0]                  frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_sel_r   <= '0;
      frame_width_r  <= 12'd2048;
      frame_height_r <= 13'd4096;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbemb_pkg::CFG_KERNEL: kernel_sel_r   <= cfg_data[rgbemb_pkg::KselW-1:0];
        rgbemb_pkg::CFG_WIDTH:  frame_width_r  <= cfg_data[11:0];
        rgbemb_pkg::CFG_HEIGHT: frame_height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Line store clearing sweep after reset
  logic            clearing_r;
  logic [ColW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ColW'(rgbemb_pkg::MaxWidth - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Position of the incoming beat
  logic [ColW-1:0] col_r, col_nxt, last_col_idx, cur_col;
  logic [RowW-1:0] row_r, row_nxt, last_row_idx, cur_row;
  logic            is_last_col, is_last_row, cur_emit;
  logic            accept, s1_adv;

  always_comb begin
    if (frame_width_r < 12'd3) begin
      last_col_idx = ColW'(2);
    end else if (frame_width_r > 12'(rgbemb_pkg::MaxWidth)) begin
      last_col_idx = ColW'(rgbemb_pkg::MaxWidth - 1);
    end else begin
      last_col_idx = ColW'(frame_width_r - 12'd1);
    end
    if (frame_height_r < 13'd3) begin
      last_row_idx = RowW'(2);
    end else if (frame_height_r > 13'(rgbemb_pkg::HeightLimit)) begin
      last_row_idx = RowW'(rgbemb_pkg::HeightLimit - 1);
    end else begin
      last_row_idx = RowW'(frame_height_r - 13'd1);
    end
    // Counts past the last position act as the last one
    cur_col     = (col_r > last_col_idx) ? last_col_idx : col_r;
    cur_row     = (row_r > last_row_idx) ? last_row_idx : row_r;
    is_last_col = (cur_col == last_col_idx);
    is_last_row = (cur_row == last_row_idx);
    cur_emit    = (cur_col >= ColW'(2)) && (cur_row >= RowW'(2));
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (accept) begin
      if (is_last_col) begin
        col_nxt = '0;
        row_nxt = is_last_row ? '0 : cur_row + 1'b1;
      end else begin
        col_nxt = cur_col + 1'b1;
        row_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: beat waiting for its line store data
  logic                 s1_valid_r, s1_valid_nxt;
  rgbemb_pkg::pix_t     s1_pix_r;
  logic [ColW-1:0]      s1_col_r;
  logic                 s1_emit_r;
  logic                 s1_last_r;
  logic                 out_valid_r, out_valid_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= {in_red_in, in_green_in, in_blue_in};
      s1_col_r  <= cur_col;
      s1_emit_r <= cur_emit;
      s1_last_r <= is_last_col && is_last_row;
    end
  end

  // Line store
  rgbemb_pkg::store_wr_t store_wr;
  rgbemb_pkg::pix_t      s1_top, s1_mid;

  always_comb begin
    if (clearing_r) begin
      store_wr.en     = 1'b1;
      store_wr.addr   = clr_addr_r;
      store_wr.upper  = '0;
      store_wr.middle = '0;
    end else begin
      store_wr.en     = s1_adv;
      store_wr.addr   = s1_col_r;
      store_wr.upper  = s1_mid;
      store_wr.middle = s1_pix_r;
    end
  end

  rgbemb_line_store u_line_store (
    .clk       (clk),
    .wr        (store_wr),
    .rd_en     (accept),
    .rd_addr   (cur_col),
    .rd_upper  (s1_top),
    .rd_middle (s1_mid)
  );

  // Two previous window columns: [0..2] oldest top/mid/bottom, [3..5] next column
  rgbemb_pkg::pix_t wp_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        wp_r[i] <= '0;
      end
    end else if (s1_adv) begin
      wp_r[0] <= wp_r[3];
      wp_r[1] <= wp_r[4];
      wp_r[2] <= wp_r[5];
      wp_r[3] <= s1_top;
      wp_r[4] <= s1_mid;
      wp_r[5] <= s1_pix_r;
    end
  end

  // Window cells in row-major order, then split into channel lanes
  rgbemb_pkg::pix_t  win_cell [rgbemb_pkg::TapCount];
  rgbemb_pkg::win_t  lane_win [3];
  rgbemb_pkg::chan_t lane_res [3];

  always_comb begin
    win_cell[0] = wp_r[0];
    win_cell[1] = wp_r[3];
    win_cell[2] = s1_top;
    win_cell[3] = wp_r[1];
    win_cell[4] = wp_r[4];
    win_cell[5] = s1_mid;
    win_cell[6] = wp_r[2];
    win_cell[7] = wp_r[5];
    win_cell[8] = s1_pix_r;
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    always_comb begin
      for (int i = 0; i < rgbemb_pkg::TapCount; i++) begin
        lane_win[ch][i] = win_cell[i][rgbemb_pkg::PixW-1-rgbemb_pkg::ChanW*ch -:
                                      rgbemb_pkg::ChanW];
      end
    end

    rgbemb_lane u_lane (
      .kernel_sel (kernel_sel_r),
      .win        (lane_win[ch]),
      .result     (lane_res[ch])
    );
  end

  // Output register merges the lanes into one result beat
  rgbemb_pkg::chan_t out_red_r, out_green_r, out_blue_r;
  logic              out_frame_end_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_emit_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_red_r       <= lane_res[0];
      out_green_r     <= lane_res[1];
      out_blue_r      <= lane_res[2];
      out_frame_end_r <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;
  assign out_frame_end = out_frame_end_r;

  // Checks
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_valid_r && !out_valid_r))
    else $error("beat in flight during line store clear");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_last_col && is_last_row) |=> (col_r == '0 && row_r == '0))
    else $error("position counters did not wrap at frame end");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_pix_r)))
    else $error("stage 1 beat changed while held");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the 3x3 RGB emboss filter with random handshake idling.
module testbench;

  localparam int MaxGap       = 17;
  localparam int SettleCycles = 6;
  localparam int WideItems    = 150;
  localparam int RandomItems  = 840;
  localparam int PrintCap     = 40;

  // Corner weights per kernel, already flipped: top left, top right, bottom left, bottom right.
  localparam int CornerWt [8][4] = '{
    '{ 1,  0,  0, -1},
    '{-1,  0,  0,  1},
    '{ 0,  1, -1,  0},
    '{ 0, -1,  1,  0},
    '{ 1,  1, -1, -1},
    '{-1,  1,  1, -1},
    '{-1, -1,  1,  1},
    '{ 1, -1, -1,  1}
  };

  typedef struct {
    rgbemb_pkg::chan_t red;
    rgbemb_pkg::chan_t green;
    rgbemb_pkg::chan_t blue;
    logic              frame_end;
  } filt_pix_t;

  class emboss_checker;
    logic [rgbemb_pkg::KselW-1:0] kernel_sel;
    logic [11:0]                  width_reg;
    logic [12:0]                  height_reg;
    rgbemb_pkg::pix_t             upper_row [rgbemb_pkg::MaxWidth];
    rgbemb_pkg::pix_t             middle_row [rgbemb_pkg::MaxWidth];
    rgbemb_pkg::pix_t             prev_cols [6];
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    filt_pix_t                    pending_pixels [$];
    int                           errors;

    function new();
      kernel_sel = '0;
      width_reg  = 12'd2048;
      height_reg = 13'd4096;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (prev_cols[i]) prev_cols[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [rgbemb_pkg::CfgIdxW-1:0] idx,
                            logic [rgbemb_pkg::CfgDataW-1:0] val);
      case (idx)
        rgbemb_pkg::CFG_KERNEL: kernel_sel = val[rgbemb_pkg::KselW-1:0];
        rgbemb_pkg::CFG_WIDTH:  width_reg  = val[11:0];
        rgbemb_pkg::CFG_HEIGHT: height_reg = val[12:0];
        default: ;
      endcase
    endfunction

    function rgbemb_pkg::chan_t corner_sum(rgbemb_pkg::pix_t tl, rgbemb_pkg::pix_t tr,
                                           rgbemb_pkg::pix_t bl, rgbemb_pkg::pix_t br,
                                           int lane);
      int acc;
      acc = CornerWt[kernel_sel][0] * int'(tl[lane*rgbemb_pkg::ChanW +: rgbemb_pkg::ChanW])
          + CornerWt[kernel_sel][1] * int'(tr[lane*rgbemb_pkg::ChanW +: rgbemb_pkg::ChanW])
          + CornerWt[kernel_sel][2] * int'(bl[lane*rgbemb_pkg::ChanW +: rgbemb_pkg::ChanW])
          + CornerWt[kernel_sel][3] * int'(br[lane*rgbemb_pkg::ChanW +: rgbemb_pkg::ChanW]);
      if (acc > 255) acc = 255;
      if (acc < 0) acc = 0;
      return rgbemb_pkg::chan_t'(acc);
    endfunction

    // Advance the window by one beat and queue the filtered pixel if the window is full.
    function void emboss_step(rgbemb_pkg::chan_t red, rgbemb_pkg::chan_t green,
                              rgbemb_pkg::chan_t blue);
      int unsigned      wd, ht, col, row;
      rgbemb_pkg::pix_t px, top, mid;
      filt_pix_t        res;
      wd = width_reg;
      if (wd < 3) wd = 3;
      if (wd > rgbemb_pkg::MaxWidth) wd = rgbemb_pkg::MaxWidth;
      ht = height_reg;
      if (ht < 3) ht = 3;
      if (ht > rgbemb_pkg::HeightLimit) ht = rgbemb_pkg::HeightLimit;
      // clamp counts that sit past a shrunken frame onto its last position
      col = (col_pos > wd - 1) ? wd - 1 : col_pos;
      row = (row_pos > ht - 1) ? ht - 1 : row_pos;
      px  = {red, green, blue};
      top = upper_row[col];
      mid = middle_row[col];
      if (row >= 2 && col >= 2) begin
        res.red       = corner_sum(prev_cols[0], top, prev_cols[2], px, 2);
        res.green     = corner_sum(prev_cols[0], top, prev_cols[2], px, 1);
        res.blue      = corner_sum(prev_cols[0], top, prev_cols[2], px, 0);
        res.frame_end = (row == ht - 1) && (col == wd - 1);
        pending_pixels.push_back(res);
      end
      prev_cols[0] = prev_cols[3];
      prev_cols[1] = prev_cols[4];
      prev_cols[2] = prev_cols[5];
      prev_cols[3] = top;
      prev_cols[4] = mid;
      prev_cols[5] = px;
      upper_row[col]  = mid;
      middle_row[col] = px;
      if (col == wd - 1) begin
        col_pos = 0;
        row_pos = (row == ht - 1) ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
        row_pos = row;
      end
    endfunction

    task report(string msg);
      if (errors < PrintCap) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_pixel(rgbemb_pkg::chan_t red, rgbemb_pkg::chan_t green,
                       rgbemb_pkg::chan_t blue, logic frame_end);
      filt_pix_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected beat r=%0d g=%0d b=%0d end=%0b",
                         red, green, blue, frame_end));
        return;
      end
      want = pending_pixels.pop_front();
      if (red !== want.red)
        report($sformatf("red got %0d want %0d", red, want.red));
      if (green !== want.green)
        report($sformatf("green got %0d want %0d", green, want.green));
      if (blue !== want.blue)
        report($sformatf("blue got %0d want %0d", blue, want.blue));
      if (frame_end !== want.frame_end)
        report($sformatf("frame_end got %0b want %0b", frame_end, want.frame_end));
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  rgbemb_pkg::chan_t               in_red;
  rgbemb_pkg::chan_t               in_green;
  rgbemb_pkg::chan_t               in_blue;
  logic                            out_valid;
  logic                            out_stall;
  rgbemb_pkg::chan_t               out_red;
  rgbemb_pkg::chan_t               out_green;
  rgbemb_pkg::chan_t               out_blue;
  logic                            out_frame_end;
  logic                            cfg_wr_en;
  logic [rgbemb_pkg::CfgIdxW-1:0]  cfg_index;
  logic [rgbemb_pkg::CfgDataW-1:0] cfg_data;

  emboss_checker sb;
  bit            in_quiet;
  bit            out_quiet;
  int unsigned   hold_left;
  int            random_sent;

  rgb_emboss_filter_3x3 i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_in     (in_red),
    .in_green_in   (in_green),
    .in_blue_in    (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red),
    .out_green_out (out_green),
    .out_blue_out  (out_blue),
    .out_frame_end (out_frame_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: check each accepted beat, then hold stall for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        sb.compare_pixel(out_red, out_green, out_blue, out_frame_end);
        hold_left = out_quiet ? 0 : $urandom_range(MaxGap, 0);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  function automatic rgbemb_pkg::chan_t rand_chan();
    case ($urandom_range(7, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return rgbemb_pkg::chan_t'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic rgbemb_pkg::chan_t rail_chan();
    return $urandom_range(1, 0) ? 8'd255 : 8'd0;
  endfunction

  task automatic send_pixel(input rgbemb_pkg::chan_t red, input rgbemb_pkg::chan_t green,
                            input rgbemb_pkg::chan_t blue);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(MaxGap, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= red;
    in_green <= green;
    in_blue  <= blue;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.emboss_step(red, green, blue);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_pixels.size() != 0);
  endtask

  task automatic write_reg(input logic [rgbemb_pkg::CfgIdxW-1:0] idx,
                           input logic [rgbemb_pkg::CfgDataW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Drain, let beats without results leave the pipe, then program all three registers.
  task automatic set_frame(input logic [rgbemb_pkg::CfgDataW-1:0] kdata,
                           input logic [rgbemb_pkg::CfgDataW-1:0] wdata,
                           input logic [rgbemb_pkg::CfgDataW-1:0] hdata);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    write_reg(rgbemb_pkg::CFG_KERNEL, kdata);
    write_reg(rgbemb_pkg::CFG_WIDTH, wdata);
    write_reg(rgbemb_pkg::CFG_HEIGHT, hdata);
    cfg_wr_en <= 1'b0;
    in_quiet  = ($urandom_range(3, 0) == 0);
    out_quiet = ($urandom_range(3, 0) == 0);
  endtask

  initial begin
    logic [9:0]                      junk;
    logic [2:0]                      ksel;
    logic [rgbemb_pkg::CfgDataW-1:0] wdat;
    logic [rgbemb_pkg::CfgDataW-1:0] hdat;
    int                              n_items;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = rgbemb_pkg::CFG_KERNEL;
    cfg_data  = '0;
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame from out-of-range size writes; kernel 4 with junk in the upper data bits
    // drives red over the top, green under zero and blue just above it
    set_frame(13'h1FFC, 13'd0, 13'd1);
    for (int i = 0; i < 9; i++) begin
      case (i / 3)
        0: send_pixel(8'd255, 8'd0, 8'd128);
        1: send_pixel(8'd17, 8'd200, 8'd3);
        default: send_pixel(8'd0, 8'd255, 8'd127);
      endcase
    end

    // shrink the frame mid-row: the column count lands past the new last column
    set_frame(13'd2, 13'd5, 13'd8191);
    for (int i = 0; i < 13; i++) send_pixel(rail_chan(), rail_chan(), rail_chan());
    set_frame(13'd3, 13'd3, 13'd3);
    send_pixel(rail_chan(), rail_chan(), rail_chan());

    // widest frame, cut short partway through its first row
    set_frame(13'd5, 13'd2048, 13'd3);
    for (int i = 0; i < WideItems; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());

    // tallest frame, left unfinished for the next setting to cut short
    set_frame(13'd6, 13'd3, 13'd4096);
    for (int i = 0; i < 40; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());

    random_sent = 0;
    for (int ph = 0; random_sent < RandomItems; ph++) begin
      junk = 10'($urandom_range(1023, 0));
      ksel = (ph < 8) ? 3'(ph) : 3'($urandom_range(7, 0));
      case ($urandom_range(9, 0))
        0: wdat = 13'($urandom_range(2, 0));
        1: wdat = 13'($urandom_range(8191, 2049));
        default: wdat = 13'($urandom_range(12, 3));
      endcase
      case ($urandom_range(9, 0))
        0: hdat = 13'($urandom_range(2, 0));
        1: hdat = 13'($urandom_range(8191, 4000));
        default: hdat = 13'($urandom_range(8, 3));
      endcase
      set_frame({junk, ksel}, wdat, hdat);
      n_items = $urandom_range(150, 20);
      for (int i = 0; i < n_items; i++) begin
        // now and then hold off until everything in flight has come out
        if ($urandom_range(59, 0) == 0) wait_drained();
        send_pixel(rand_chan(), rand_chan(), rand_chan());
        random_sent++;
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
